FILE: design/assert_macros.svh
// Assertion macros for the hasher RTL, used by fnv64h_ctrl.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: design/fnv64h_pkg.sv
// Package for the typed FNV-1a 64-bit stream hasher.
// Holds kind codes, the controller-to-datapath command struct and hash helpers.
// No dependencies.
package fnv64h_pkg;

    localparam int unsigned HashW = 64;
    localparam int unsigned KindW = 3;
    localparam int unsigned CntW  = 3;

    localparam logic [HashW-1:0] FnvBasis = 64'hcbf2_9ce4_8422_2325;
    localparam logic [HashW-1:0] QNan64   = 64'h7ff8_0000_0000_0000;
    localparam logic [31:0]      QNan32   = 32'h7fc0_0000;

    typedef enum logic [KindW-1:0] {
        KIND_BYTE = 3'd0,
        KIND_U32  = 3'd1,
        KIND_U64  = 3'd2,
        KIND_F32  = 3'd3,
        KIND_F64  = 3'd4
    } kind_t;

    typedef struct packed {
        logic load;      // item accepted: load word, absorb first byte
        logic restart;   // reload state from seed before absorbing
        logic step;      // absorb next byte of the held word
        logic out_load;  // capture next hash into output register
    } cmd_t;

    // Number of bytes absorbed for a kind; unused kinds absorb nothing.
    function automatic logic [3:0] byte_count(input logic [KindW-1:0] kind);
        logic [3:0] n;
        case (kind)
            KIND_BYTE: n = 4'd1;
            KIND_U32:  n = 4'd4;
            KIND_U64:  n = 4'd8;
            KIND_F32:  n = 4'd4;
            KIND_F64:  n = 4'd8;
            default:   n = 4'd0;
        endcase
        return n;
    endfunction

    // Word to absorb, little-endian from bit 0, floats canonicalized.
    function automatic logic [HashW-1:0] canon_word(input logic [KindW-1:0] kind,
                                                    input logic [HashW-1:0] value);
        logic [HashW-1:0] w;
        logic [31:0]      f;
        f = value[31:0];
        case (kind)
            KIND_BYTE: w = {56'd0, value[7:0]};
            KIND_U32:  w = {32'd0, value[31:0]};
            KIND_U64:  w = value;
            KIND_F32:
            begin
                if (f[30:23] == 8'hff && f[22:0] != 23'd0)
                begin
                    w = {32'd0, QNan32};
                end
                else if (f == 32'h8000_0000)
                begin
                    w = '0;
                end
                else
                begin
                    w = {32'd0, f};
                end
            end
            KIND_F64:
            begin
                if (value[62:52] == 11'h7ff && value[51:0] != 52'd0)
                begin
                    w = QNan64;
                end
                else if (value == 64'h8000_0000_0000_0000)
                begin
                    w = '0;
                end
                else
                begin
                    w = value;
                end
            end
            default:   w = '0;
        endcase
        return w;
    endfunction

    // Multiply by the FNV prime 2^40 + 0x1b3, modulo 2^64, as shifts and adds.
    function automatic logic [HashW-1:0] fnv_mul(input logic [HashW-1:0] h);
        return (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
    endfunction

endpackage

FILE: design/fnv64h_dp.sv
// Datapath of the hasher: seed register, hash state, byte shifter, output register.
// Driven by fnv64h_ctrl through fnv64h_pkg::cmd_t; uses fnv64h_pkg helpers.
module fnv64h_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  seed_we,
    input  logic [fnv64h_pkg::HashW-1:0]          seed_wdata,
    input  fnv64h_pkg::cmd_t                      cmd,
    input  logic [fnv64h_pkg::KindW-1:0]          kind,
    input  logic [fnv64h_pkg::HashW-1:0]          value,
    output logic [fnv64h_pkg::HashW-1:0]          hash_out
);

    logic [fnv64h_pkg::HashW-1:0] seed_reg, seed_next;
    logic [fnv64h_pkg::HashW-1:0] hash_reg, hash_next;
    logic [fnv64h_pkg::HashW-1:0] word_reg, word_next;
    logic [fnv64h_pkg::HashW-1:0] out_reg, out_next;
    logic [fnv64h_pkg::HashW-1:0] canon;
    logic [fnv64h_pkg::HashW-1:0] base;
    logic [7:0]                   cur_byte;
    logic                         absorb;

    assign canon = fnv64h_pkg::canon_word(kind, value);

    always_comb
    begin
        base      = (cmd.load && cmd.restart) ? seed_reg : hash_reg;
        cur_byte  = cmd.load ? canon[7:0] : word_reg[7:0];
        absorb    = cmd.step || (cmd.load && fnv64h_pkg::byte_count(kind) != 4'd0);
        hash_next = absorb ? fnv64h_pkg::fnv_mul(base ^ {56'd0, cur_byte}) : base;

        if (cmd.load)
        begin
            word_next = canon >> 8;
        end
        else if (cmd.step)
        begin
            word_next = word_reg >> 8;
        end
        else
        begin
            word_next = word_reg;
        end

        seed_next = seed_we ? seed_wdata : seed_reg;
        out_next  = cmd.out_load ? hash_next : out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= fnv64h_pkg::FnvBasis;
            hash_reg <= fnv64h_pkg::FnvBasis;
        end
        else
        begin
            seed_reg <= seed_next;
            hash_reg <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        out_reg  <= out_next;
    end

    assign hash_out = out_reg;

endmodule

FILE: design/fnv64h_ctrl.sv
// Controller of the hasher: input/output handshakes and byte step sequencing.
// Uses fnv64h_pkg (cmd_t, byte_count) and assert_macros.svh.
`include "assert_macros.svh"

module fnv64h_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [fnv64h_pkg::KindW-1:0]  kind,
    input  logic                          restart,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output fnv64h_pkg::cmd_t              cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_BUSY   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    logic [fnv64h_pkg::CntW-1:0] cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_free;
    logic [3:0]                  nbytes;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign nbytes   = fnv64h_pkg::byte_count(kind);

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load    = 1'b1;
                    cmd.restart = restart;
                    if (nbytes > 4'd1)
                    begin
                        // first byte goes in now; cnt counts the rest minus one
                        cnt_next   = fnv64h_pkg::CntW'(nbytes - 4'd2);
                        state_next = ST_BUSY;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_BUSY:
            begin
                cmd.step = 1'b1;
                if (cnt_reg == '0)
                begin
                    if (out_free)
                    begin
                        cmd.out_load = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = cmd.out_load || (out_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;

    `ASSERT_NEVER(a_no_overwrite, cmd.out_load && out_valid_reg && !m_axis_tready, "result overwritten before taken")
    `ASSERT_CLK(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "accepted a second item while working")
    `ASSERT_CLK(a_hold_on_stall, state_reg == ST_BUSY && cnt_reg == '0 && !out_free |=> state_reg == ST_FINISH, "finished hash lost on output stall")
    `ASSERT_NEVER(a_load_and_step, cmd.load && cmd.step, "load and step in the same cycle")

endmodule

FILE: design/fnv64h_top.sv
// Top level of the typed FNV-1a 64-bit stream hasher.
// Instantiates fnv64h_ctrl and fnv64h_dp; uses fnv64h_pkg.
//
//  channel   direction  tdata              tuser
//  s_axis    in         value[63:0]        kind[2:0], restart[3]
//  m_axis    out        hash[63:0]         -
//  seed      cfg write  seed_wdata[63:0]   -
//
// Bytes go in one byte a cycle, low byte first, through the shift-add FNV multiply:
// 8 for u64/f64, 4 for u32/f32, 1 for a byte and none for an unused kind. A new
// item is accepted only in idle, after the previous one is absorbed.
// The next item is taken while the previous hash waits in the output register.
// A stalled m_axis holds the finished item until the output register frees.
// Reset loads seed and hash state with the FNV offset basis; output is empty.
module fnv1a64_typed_stream_hasher_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [63:0]                  s_axis_tdata,   // value[63:0]
    input  logic [3:0]                   s_axis_tuser,   // kind[2:0], restart[3]
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [63:0]                  m_axis_tdata,   // hash[63:0]
    input  logic                         seed_we,
    input  logic [63:0]                  seed_wdata
);

    fnv64h_pkg::cmd_t cmd;

    fnv64h_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .kind          (s_axis_tuser[2:0]),
        .restart       (s_axis_tuser[3]),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd)
    );

    fnv64h_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_we    (seed_we),
        .seed_wdata (seed_wdata),
        .cmd        (cmd),
        .kind       (s_axis_tuser[2:0]),
        .value      (s_axis_tdata),
        .hash_out   (m_axis_tdata)
    );

endmodule
